>>> src/color_blob_centroid_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color blob centroid tracker
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef COLOR_BLOB_CENTROID_TRACKER_MACROS_SVH
`define COLOR_BLOB_CENTROID_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must never hold outside reset
`define CBCT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("cbct: forbidden condition seen");

// ante implies cons in the same cycle
`define CBCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbct: implication failed");

// ante implies cons in the next cycle
`define CBCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbct: next-cycle implication failed");

`else

`define CBCT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define CBCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CBCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/cbct_pkg.sv
// ----------------------------------------------------------------------------
// cbct_pkg
// Shared widths, register codes and types of the color blob centroid tracker.
// ----------------------------------------------------------------------------
package cbct_pkg;

	localparam int XW    = 10;  // column / centroid x
	localparam int YW    = 9;   // row / centroid y
	localparam int CNTW  = 19;  // pixel count
	localparam int SUMW  = 28;  // coordinate sums
	localparam int HW    = 8;   // hue, sat, val
	localparam int ADDRW = 5;
	localparam int DATAW = 32;
	localparam int QDEPTH = 2;  // frame totals queue

	localparam int DEF_FRAME_WIDTH  = 640;
	localparam int DEF_FRAME_HEIGHT = 480;

	localparam logic [CNTW-1:0] COUNT_MAX = '1;

	localparam logic [HW-1:0]   RST_HUE_LOW_A  = 8'd75;
	localparam logic [HW-1:0]   RST_HUE_HIGH_A = 8'd130;
	localparam logic [HW-1:0]   RST_HUE_LOW_B  = 8'd10;
	localparam logic [HW-1:0]   RST_HUE_HIGH_B = 8'd22;
	localparam logic [HW-1:0]   RST_SAT_MIN    = 8'd160;
	localparam logic [HW-1:0]   RST_VAL_MIN    = 8'd60;
	localparam logic [CNTW-1:0] RST_MIN_AREA   = 19'd500;

	typedef enum logic [2:0] {
		REG_HUE_LOW_A  = 3'd0,
		REG_HUE_HIGH_A = 3'd1,
		REG_HUE_LOW_B  = 3'd2,
		REG_HUE_HIGH_B = 3'd3,
		REG_SAT_MIN    = 3'd4,
		REG_VAL_MIN    = 3'd5,
		REG_MIN_AREA   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [HW-1:0]   hue_low_a;
		logic [HW-1:0]   hue_high_a;
		logic [HW-1:0]   hue_low_b;
		logic [HW-1:0]   hue_high_b;
		logic [HW-1:0]   sat_min;
		logic [HW-1:0]   val_min;
		logic [CNTW-1:0] min_area;
	} cfg_t;

	typedef struct packed {
		logic [CNTW-1:0] count;
		logic [SUMW-1:0] sum_x;
		logic [SUMW-1:0] sum_y;
	} class_tot_t;

	typedef struct packed {
		class_tot_t a;
		class_tot_t b;
	} frame_tot_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic            found;
		logic [XW-1:0]   center_x;
		logic [YW-1:0]   center_y;
		logic [CNTW-1:0] pixels;
	} class_res_t;

endpackage

>>> src/color_blob_centroid_tracker.sv
// ----------------------------------------------------------------------------
// color_blob_centroid_tracker
// Two-class HSV threshold blob tracker with per-frame centroid by moments.
// ----------------------------------------------------------------------------
// Pixels stream in raster order, one request per clock unless stalled, with
// end_of_line and end_of_frame marks. A pixel matches class a or b when its
// hue lies inside that class's inclusive hue window and sat >= sat_min and
// val >= val_min. Per class the intake keeps a match count and sums of column
// and row; a pixel overflowing the count or a sum is dropped for that class.
// On the end-of-frame pixel the totals go into a two-entry queue and the
// accumulators restart, so the next frame is taken without a gap. The finish
// stage then runs four restoring divisions (x and y for each class) on one
// shared divider, one quotient bit per clock, before the frame's result
// request is offered. A class whose count exceeds min_area gets the new
// centroid; otherwise the last centroid is repeated. pixel stall rises only
// while the queue holds two unfinished frames, which the blanking interval of
// any real video stream avoids.
// Configuration is an APB-style port: registers at byte address 4*index
// (hue_low_a, hue_high_a, hue_low_b, hue_high_b, sat_min, val_min,
// min_area); write only while no frame is in flight.
// ----------------------------------------------------------------------------
`include "color_blob_centroid_tracker_macros.svh"

module color_blob_centroid_tracker #(
	parameter int FRAME_WIDTH  = cbct_pkg::DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = cbct_pkg::DEF_FRAME_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cbct_pkg::ADDRW-1:0]   paddr,
	input  logic [cbct_pkg::DATAW-1:0]   pwdata,
	output logic [cbct_pkg::DATAW-1:0]   prdata,
	output logic                         pready,
	// pixel channel
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  logic [cbct_pkg::HW-1:0]      hue,
	input  logic [cbct_pkg::HW-1:0]      sat,
	input  logic [cbct_pkg::HW-1:0]      val,
	input  logic                         end_of_line,
	input  logic                         end_of_frame,
	// result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         found_a,
	output logic [cbct_pkg::XW-1:0]      center_x_a,
	output logic [cbct_pkg::YW-1:0]      center_y_a,
	output logic [cbct_pkg::CNTW-1:0]    pixels_a,
	output logic                         found_b,
	output logic [cbct_pkg::XW-1:0]      center_x_b,
	output logic [cbct_pkg::YW-1:0]      center_y_b,
	output logic [cbct_pkg::CNTW-1:0]    pixels_b
);

	cbct_pkg::cfg_t        cfg_q;
	cbct_pkg::reg_idx_t    reg_idx;
	logic                  cfg_wr;
	cbct_pkg::q_status_t   q_stat;
	logic                  q_push;
	logic                  q_pop;
	cbct_pkg::frame_tot_t  q_in;
	cbct_pkg::frame_tot_t  q_out;
	cbct_pkg::class_res_t  res_a;
	cbct_pkg::class_res_t  res_b;

	// ---- configuration registers ----
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = cbct_pkg::reg_idx_t'(paddr[cbct_pkg::ADDRW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_low_a  <= cbct_pkg::RST_HUE_LOW_A;
			cfg_q.hue_high_a <= cbct_pkg::RST_HUE_HIGH_A;
			cfg_q.hue_low_b  <= cbct_pkg::RST_HUE_LOW_B;
			cfg_q.hue_high_b <= cbct_pkg::RST_HUE_HIGH_B;
			cfg_q.sat_min    <= cbct_pkg::RST_SAT_MIN;
			cfg_q.val_min    <= cbct_pkg::RST_VAL_MIN;
			cfg_q.min_area   <= cbct_pkg::RST_MIN_AREA;
		end else if (cfg_wr) begin
			case (reg_idx)
				cbct_pkg::REG_HUE_LOW_A:  cfg_q.hue_low_a  <= pwdata[cbct_pkg::HW-1:0];
				cbct_pkg::REG_HUE_HIGH_A: cfg_q.hue_high_a <= pwdata[cbct_pkg::HW-1:0];
				cbct_pkg::REG_HUE_LOW_B:  cfg_q.hue_low_b  <= pwdata[cbct_pkg::HW-1:0];
				cbct_pkg::REG_HUE_HIGH_B: cfg_q.hue_high_b <= pwdata[cbct_pkg::HW-1:0];
				cbct_pkg::REG_SAT_MIN:    cfg_q.sat_min    <= pwdata[cbct_pkg::HW-1:0];
				cbct_pkg::REG_VAL_MIN:    cfg_q.val_min    <= pwdata[cbct_pkg::HW-1:0];
				cbct_pkg::REG_MIN_AREA:   cfg_q.min_area   <= pwdata[cbct_pkg::CNTW-1:0];
				default: ;
			endcase
		end
	end

	// readback, unused addresses read as zero
	always_comb begin
		prdata = '0;
		case (reg_idx)
			cbct_pkg::REG_HUE_LOW_A:  prdata = cbct_pkg::DATAW'(cfg_q.hue_low_a);
			cbct_pkg::REG_HUE_HIGH_A: prdata = cbct_pkg::DATAW'(cfg_q.hue_high_a);
			cbct_pkg::REG_HUE_LOW_B:  prdata = cbct_pkg::DATAW'(cfg_q.hue_low_b);
			cbct_pkg::REG_HUE_HIGH_B: prdata = cbct_pkg::DATAW'(cfg_q.hue_high_b);
			cbct_pkg::REG_SAT_MIN:    prdata = cbct_pkg::DATAW'(cfg_q.sat_min);
			cbct_pkg::REG_VAL_MIN:    prdata = cbct_pkg::DATAW'(cfg_q.val_min);
			cbct_pkg::REG_MIN_AREA:   prdata = cbct_pkg::DATAW'(cfg_q.min_area);
			default:                  prdata = '0;
		endcase
	end

	// ---- pixel intake and accumulation ----
	cbct_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.hue          (hue),
		.sat          (sat),
		.val          (val),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame),
		.q_full       (q_stat.full),
		.push         (q_push),
		.push_data    (q_in)
	);

	// ---- frame totals queue ----
	cbct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.status    (q_stat)
	);

	// ---- division and result register ----
	cbct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_area  (cfg_q.min_area),
		.q_empty   (q_stat.empty),
		.pop_data  (q_out),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_a     (res_a),
		.res_b     (res_b)
	);

	assign found_a    = res_a.found;
	assign center_x_a = res_a.center_x;
	assign center_y_a = res_a.center_y;
	assign pixels_a   = res_a.pixels;
	assign found_b    = res_b.found;
	assign center_x_b = res_b.center_x;
	assign center_y_b = res_b.center_y;
	assign pixels_b   = res_b.pixels;

	// ---- checks ----
	`CBCT_ASSERT_NEVER(a_q_full_and_empty, clk, arst_n, q_stat.full && q_stat.empty)
	`CBCT_ASSERT_IMP(a_push_not_full, clk, arst_n, q_push, !q_stat.full)
	`CBCT_ASSERT_IMP(a_pop_not_empty, clk, arst_n, q_pop, !q_stat.empty)
	`CBCT_ASSERT_NXT(a_result_spacing, clk, arst_n, res_valid && !res_stall, !res_valid)

endmodule

>>> src/cbct_front.sv
// ----------------------------------------------------------------------------
// cbct_front
// Pixel intake: classify each pixel, accumulate count and coordinate sums,
// push the frame totals into the queue on the end-of-frame pixel.
// ----------------------------------------------------------------------------
module cbct_front #(
	parameter int FRAME_WIDTH  = cbct_pkg::DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = cbct_pkg::DEF_FRAME_HEIGHT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cbct_pkg::cfg_t              cfg,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  logic [cbct_pkg::HW-1:0]     hue,
	input  logic [cbct_pkg::HW-1:0]     sat,
	input  logic [cbct_pkg::HW-1:0]     val,
	input  logic                        end_of_line,
	input  logic                        end_of_frame,
	input  logic                        q_full,
	output logic                        push,
	output cbct_pkg::frame_tot_t        push_data
);

	localparam logic [cbct_pkg::XW-1:0] COL_LAST = cbct_pkg::XW'(FRAME_WIDTH - 1);
	localparam logic [cbct_pkg::YW-1:0] ROW_LAST = cbct_pkg::YW'(FRAME_HEIGHT - 1);

	// add one pixel unless count or either sum would overflow
	function automatic cbct_pkg::class_tot_t acc_next(
		input cbct_pkg::class_tot_t  cur,
		input logic                  hit,
		input logic [cbct_pkg::XW-1:0] x,
		input logic [cbct_pkg::YW-1:0] y
	);
		logic [cbct_pkg::SUMW:0] nx;
		logic [cbct_pkg::SUMW:0] ny;
		cbct_pkg::class_tot_t    r;
		nx = {1'b0, cur.sum_x} + (cbct_pkg::SUMW + 1)'(x);
		ny = {1'b0, cur.sum_y} + (cbct_pkg::SUMW + 1)'(y);
		r  = cur;
		if (hit && cur.count != cbct_pkg::COUNT_MAX && !nx[cbct_pkg::SUMW]
				&& !ny[cbct_pkg::SUMW]) begin
			r.count = cur.count + 1'b1;
			r.sum_x = nx[cbct_pkg::SUMW-1:0];
			r.sum_y = ny[cbct_pkg::SUMW-1:0];
		end
		return r;
	endfunction

	logic [cbct_pkg::XW-1:0] col_q;
	logic [cbct_pkg::YW-1:0] row_q;
	cbct_pkg::frame_tot_t    tot_q;
	cbct_pkg::frame_tot_t    tot_next;
	logic                    sv_ok;
	logic                    hit_a;
	logic                    hit_b;
	logic                    accept;

	assign sv_ok = (sat >= cfg.sat_min) && (val >= cfg.val_min);
	assign hit_a = sv_ok && (hue >= cfg.hue_low_a) && (hue <= cfg.hue_high_a);
	assign hit_b = sv_ok && (hue >= cfg.hue_low_b) && (hue <= cfg.hue_high_b);

	assign tot_next.a = acc_next(tot_q.a, hit_a, col_q, row_q);
	assign tot_next.b = acc_next(tot_q.b, hit_b, col_q, row_q);

	assign pix_stall = q_full;
	assign accept    = pix_valid && !q_full;
	assign push      = accept && end_of_frame;
	assign push_data = tot_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			tot_q <= '0;
		end else if (accept) begin
			if (end_of_frame) begin
				col_q <= '0;
				row_q <= '0;
				tot_q <= '0;
			end else begin
				tot_q <= tot_next;
				if (end_of_line) begin
					col_q <= '0;
					if (row_q < ROW_LAST) row_q <= row_q + 1'b1;
				end else if (col_q < COL_LAST) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> src/cbct_queue.sv
// ----------------------------------------------------------------------------
// cbct_queue
// Small register queue of frame totals between intake and division.
// ----------------------------------------------------------------------------
module cbct_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cbct_pkg::frame_tot_t   push_data,
	input  logic                   pop,
	output cbct_pkg::frame_tot_t   pop_data,
	output cbct_pkg::q_status_t    status
);

	localparam int PW = (cbct_pkg::QDEPTH > 1) ? $clog2(cbct_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(cbct_pkg::QDEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(cbct_pkg::QDEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(cbct_pkg::QDEPTH);

	cbct_pkg::frame_tot_t mem_q [cbct_pkg::QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign status.full  = (cnt_q == CNT_FULL);
	assign status.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/cbct_back.sv
// ----------------------------------------------------------------------------
// cbct_back
// Frame finish: four restoring divisions on one shared divider, centroid
// hold logic and the result register.
// ----------------------------------------------------------------------------
module cbct_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cbct_pkg::CNTW-1:0]  min_area,
	input  logic                       q_empty,
	input  cbct_pkg::frame_tot_t       pop_data,
	output logic                       pop,
	output logic                       res_valid,
	input  logic                       res_stall,
	output cbct_pkg::class_res_t       res_a,
	output cbct_pkg::class_res_t       res_b
);

	localparam int XW   = cbct_pkg::XW;
	localparam int YW   = cbct_pkg::YW;
	localparam int SUMW = cbct_pkg::SUMW;
	localparam int TW   = cbct_pkg::CNTW + XW;     // shifted divisor width
	localparam int SW   = $clog2(XW);
	localparam logic [SW-1:0] STEP_FIRST = SW'(XW - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_OUT  = 3'b100
	} back_state_t;

	typedef enum logic [1:0] {
		OP_XA = 2'd0,
		OP_YA = 2'd1,
		OP_XB = 2'd2,
		OP_YB = 2'd3
	} op_t;

	back_state_t          state_q;
	op_t                  op_q;
	op_t                  op_nxt;
	cbct_pkg::frame_tot_t work_q;
	logic [SUMW-1:0]      rem_q;
	logic [TW-1:0]        dvs_q;
	logic [XW-1:0]        quo_q;
	logic [SW-1:0]        step_q;
	logic [XW-1:0]        qxa_q;
	logic [XW-1:0]        qya_q;
	logic [XW-1:0]        qxb_q;
	logic [XW-1:0]        held_xa_q;
	logic [YW-1:0]        held_ya_q;
	logic [XW-1:0]        held_xb_q;
	logic [YW-1:0]        held_yb_q;
	cbct_pkg::class_res_t res_a_q;
	cbct_pkg::class_res_t res_b_q;

	logic [TW-1:0]   rem_ext;
	logic            ge;
	logic [XW-1:0]   quo_fin;
	logic [SUMW-1:0] nxt_dividend;
	logic [TW-1:0]   nxt_divisor;
	logic            found_a;
	logic            found_b;
	logic [XW-1:0]   new_xa;
	logic [YW-1:0]   new_ya;
	logic [XW-1:0]   new_xb;
	logic [YW-1:0]   new_yb;

	// one quotient bit a cycle, msb first
	assign rem_ext = TW'(rem_q);
	assign ge      = rem_ext >= dvs_q;
	assign quo_fin = {quo_q[XW-2:0], ge};

	always_comb begin
		op_nxt = OP_XA;
		case (op_q)
			OP_XA:   op_nxt = OP_YA;
			OP_YA:   op_nxt = OP_XB;
			OP_XB:   op_nxt = OP_YB;
			default: op_nxt = OP_XA;
		endcase
	end

	// operands of the division after the current one
	always_comb begin
		nxt_dividend = work_q.a.sum_y;
		nxt_divisor  = TW'(work_q.a.count) << (XW - 1);
		case (op_q)
			OP_XA: begin
				nxt_dividend = work_q.a.sum_y;
				nxt_divisor  = TW'(work_q.a.count) << (XW - 1);
			end
			OP_YA: begin
				nxt_dividend = work_q.b.sum_x;
				nxt_divisor  = TW'(work_q.b.count) << (XW - 1);
			end
			default: begin
				nxt_dividend = work_q.b.sum_y;
				nxt_divisor  = TW'(work_q.b.count) << (XW - 1);
			end
		endcase
	end

	assign found_a = work_q.a.count > min_area;
	assign found_b = work_q.b.count > min_area;
	assign new_xa  = found_a ? qxa_q : held_xa_q;
	assign new_ya  = found_a ? qya_q[YW-1:0] : held_ya_q;
	assign new_xb  = found_b ? qxb_q : held_xb_q;
	assign new_yb  = found_b ? quo_fin[YW-1:0] : held_yb_q;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign res_valid = (state_q == ST_OUT);
	assign res_a     = res_a_q;
	assign res_b     = res_b_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= pop_data;
			rem_q  <= pop_data.a.sum_x;
			dvs_q  <= TW'(pop_data.a.count) << (XW - 1);
			quo_q  <= '0;
		end else if (state_q == ST_DIV) begin
			if (step_q == '0) begin
				case (op_q)
					OP_XA:   qxa_q <= quo_fin;
					OP_YA:   qya_q <= quo_fin;
					OP_XB:   qxb_q <= quo_fin;
					default: begin
						res_a_q <= '{found_a, new_xa, new_ya, work_q.a.count};
						res_b_q <= '{found_b, new_xb, new_yb, work_q.b.count};
					end
				endcase
				rem_q <= nxt_dividend;
				dvs_q <= nxt_divisor;
				quo_q <= '0;
			end else begin
				if (ge) rem_q <= SUMW'(rem_ext - dvs_q);
				dvs_q <= dvs_q >> 1;
				quo_q <= quo_fin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_XA;
			step_q    <= '0;
			held_xa_q <= '0;
			held_ya_q <= '0;
			held_xb_q <= '0;
			held_yb_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
						op_q    <= OP_XA;
						step_q  <= STEP_FIRST;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						step_q <= STEP_FIRST;
						op_q   <= op_nxt;
						if (op_q == OP_YB) begin
							state_q   <= ST_OUT;
							held_xa_q <= new_xa;
							held_ya_q <= new_ya;
							held_xb_q <= new_xb;
							held_yb_q <= new_yb;
						end
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (!res_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> dv/color_blob_centroid_tracker_tb.sv
// ----------------------------------------------------------------------------
// color_blob_centroid_tracker_tb
// Self-checking bench: pixel frames in, per-frame two-class centroids checked.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the thresholds and of the per-class
// moment accumulators. Every accepted pixel request updates it, and every
// end-of-frame pixel queues the frame result it must produce. The result
// monitor pops that queue and compares each field. Stimulus runs in two
// parts: a handful of hand-built frames around the window edges, then random
// frames under random thresholds with random gaps on both channels.
// ----------------------------------------------------------------------------
module color_blob_centroid_tracker_tb;

	localparam int HW    = cbct_pkg::HW;
	localparam int XW    = cbct_pkg::XW;
	localparam int YW    = cbct_pkg::YW;
	localparam int CNTW  = cbct_pkg::CNTW;
	localparam int SUMW  = cbct_pkg::SUMW;
	localparam int ADDRW = cbct_pkg::ADDRW;
	localparam int DATAW = cbct_pkg::DATAW;

	typedef cbct_pkg::class_res_t class_res_t;
	typedef cbct_pkg::cfg_t       cfg_t;
	typedef cbct_pkg::reg_idx_t   reg_idx_t;

	localparam int FW = cbct_pkg::DEF_FRAME_WIDTH;
	localparam int FH = cbct_pkg::DEF_FRAME_HEIGHT;
	localparam int SETTLE_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 330;
	localparam int RANDOM_FRAMES = 12;
	localparam int AREA_TOP = 307200;

	typedef struct packed {
		logic [HW-1:0] hue;
		logic [HW-1:0] sat;
		logic [HW-1:0] val;
		logic          eol;
		logic          eof;
	} pixel_t;

	typedef struct packed {
		class_res_t a;
		class_res_t b;
	} frame_res_t;

	// ------------------------------------------------------------------------
	// Scoreboard: threshold copy, moment accumulators, queue of frame results
	// ------------------------------------------------------------------------
	class centroid_scoreboard;
		logic [HW-1:0]   hue_lo[2];
		logic [HW-1:0]   hue_hi[2];
		logic [HW-1:0]   sat_floor;
		logic [HW-1:0]   val_floor;
		logic [CNTW-1:0] area_floor;
		logic [XW-1:0]   column;
		logic [YW-1:0]   row;
		logic [CNTW-1:0] count[2];
		logic [SUMW-1:0] sum_x[2];
		logic [SUMW-1:0] sum_y[2];
		logic [XW-1:0]   held_x[2];
		logic [YW-1:0]   held_y[2];
		frame_res_t      frames_due[$];
		int              mismatches;
		int              frames_checked;

		function new();
			hue_lo[0] = cbct_pkg::RST_HUE_LOW_A;
			hue_hi[0] = cbct_pkg::RST_HUE_HIGH_A;
			hue_lo[1] = cbct_pkg::RST_HUE_LOW_B;
			hue_hi[1] = cbct_pkg::RST_HUE_HIGH_B;
			sat_floor = cbct_pkg::RST_SAT_MIN;
			val_floor = cbct_pkg::RST_VAL_MIN;
			area_floor = cbct_pkg::RST_MIN_AREA;
			column = '0;
			row = '0;
			for (int c = 0; c < 2; c++) begin
				count[c] = '0;
				sum_x[c] = '0;
				sum_y[c] = '0;
				held_x[c] = '0;
				held_y[c] = '0;
			end
			mismatches = 0;
			frames_checked = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATAW-1:0] v);
			case (idx)
				cbct_pkg::REG_HUE_LOW_A:  hue_lo[0] = v[HW-1:0];
				cbct_pkg::REG_HUE_HIGH_A: hue_hi[0] = v[HW-1:0];
				cbct_pkg::REG_HUE_LOW_B:  hue_lo[1] = v[HW-1:0];
				cbct_pkg::REG_HUE_HIGH_B: hue_hi[1] = v[HW-1:0];
				cbct_pkg::REG_SAT_MIN:    sat_floor = v[HW-1:0];
				cbct_pkg::REG_VAL_MIN:    val_floor = v[HW-1:0];
				cbct_pkg::REG_MIN_AREA:   area_floor = v[CNTW-1:0];
				default: ;
			endcase
		endfunction

		// pixel at (column,row): accumulate, then close the frame or advance
		function void take_pixel(pixel_t p);
			logic            sv_ok;
			logic [SUMW:0]   nx;
			logic [SUMW:0]   ny;
			class_res_t      res[2];
			frame_res_t      fr;
			sv_ok = (p.sat >= sat_floor) && (p.val >= val_floor);
			for (int c = 0; c < 2; c++) begin
				nx = {1'b0, sum_x[c]} + (SUMW+1)'(column);
				ny = {1'b0, sum_y[c]} + (SUMW+1)'(row);
				// a class stops growing once count or a sum would pass its width
				if (sv_ok && p.hue >= hue_lo[c] && p.hue <= hue_hi[c] &&
						count[c] != cbct_pkg::COUNT_MAX && !nx[SUMW] && !ny[SUMW]) begin
					count[c] = count[c] + 1'b1;
					sum_x[c] = nx[SUMW-1:0];
					sum_y[c] = ny[SUMW-1:0];
				end
			end
			if (p.eof) begin
				for (int c = 0; c < 2; c++) begin
					res[c].found = count[c] > area_floor;
					if (res[c].found) begin
						held_x[c] = XW'(sum_x[c] / count[c]);
						held_y[c] = YW'(sum_y[c] / count[c]);
					end
					res[c].center_x = held_x[c];
					res[c].center_y = held_y[c];
					res[c].pixels = count[c];
					count[c] = '0;
					sum_x[c] = '0;
					sum_y[c] = '0;
				end
				fr.a = res[0];
				fr.b = res[1];
				frames_due.push_back(fr);
				column = '0;
				row = '0;
			end else if (p.eol) begin
				column = '0;
				if (row < YW'(FH - 1))
					row = row + 1'b1;
			end else if (column < XW'(FW - 1)) begin
				column = column + 1'b1;
			end
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("ERROR: %s", what);
		endtask

		task compare_class(string tag, class_res_t want, class_res_t got);
			if (got.found !== want.found)
				report_mismatch($sformatf("frame %0d found_%s got %0b want %0b",
					frames_checked, tag, got.found, want.found));
			if (got.center_x !== want.center_x)
				report_mismatch($sformatf("frame %0d center_x_%s got %0d want %0d",
					frames_checked, tag, got.center_x, want.center_x));
			if (got.center_y !== want.center_y)
				report_mismatch($sformatf("frame %0d center_y_%s got %0d want %0d",
					frames_checked, tag, got.center_y, want.center_y));
			if (got.pixels !== want.pixels)
				report_mismatch($sformatf("frame %0d pixels_%s got %0d want %0d",
					frames_checked, tag, got.pixels, want.pixels));
		endtask

		task check_frame(frame_res_t got);
			frame_res_t want;
			if (frames_due.size() == 0) begin
				report_mismatch($sformatf("frame %0d: result with no frame pending",
					frames_checked));
			end else begin
				want = frames_due.pop_front();
				compare_class("a", want.a, got.a);
				compare_class("b", want.b, got.b);
			end
			frames_checked++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDRW-1:0]  paddr;
	logic [DATAW-1:0]  pwdata;
	logic [DATAW-1:0]  prdata;
	logic              pready;
	logic              pix_valid;
	logic              pix_stall;
	logic [HW-1:0]     hue;
	logic [HW-1:0]     sat;
	logic [HW-1:0]     val;
	logic              end_of_line;
	logic              end_of_frame;
	logic              res_valid;
	logic              res_stall;
	logic              found_a;
	logic [XW-1:0]     center_x_a;
	logic [YW-1:0]     center_y_a;
	logic [CNTW-1:0]   pixels_a;
	logic              found_b;
	logic [XW-1:0]     center_x_b;
	logic [YW-1:0]     center_y_b;
	logic [CNTW-1:0]   pixels_b;

	centroid_scoreboard board;
	bit  tx_idle;       // sender gaps on/off for the current phase
	bit  rx_idle;       // receiver stalls on/off for the current phase
	int  pixels_sent;
	int  random_pixels;
	int  reg_writes;
	int  quiet = 0;

	color_blob_centroid_tracker dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: any handshake on any port counts as progress
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("color_blob_centroid_tracker verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result monitor; field order matches frame_res_t packing
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_frame(frame_res_t'({found_a, center_x_a, center_y_a, pixels_a,
				found_b, center_x_b, center_y_b, pixels_b}));
	end

	// result receiver: with idling on, hold stall through a random number of
	// cycles after the result shows up so stalls land on a waiting result
	initial begin : receiver
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = rx_idle ? $urandom_range(0, 19) : 0;
			if (n > 0) begin
				res_stall <= 1'b1;
				@(posedge clk);
				while (res_valid !== 1'b1) @(posedge clk);
				repeat (n) @(negedge clk);
				res_stall <= 1'b0;
			end
			@(posedge clk);
			while (res_valid !== 1'b1) @(posedge clk);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers; every task starts and ends at a falling edge
	// ------------------------------------------------------------------------
	task automatic apb_write(reg_idx_t idx, logic [DATAW-1:0] data);
		logic [DATAW-1:0] mask;
		mask = (idx == cbct_pkg::REG_MIN_AREA) ? DATAW'(cbct_pkg::COUNT_MAX) : DATAW'(8'hFF);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDRW'({idx, 2'b00});
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		board.set_reg(idx, data & mask);
		// read it straight back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if ((prdata & mask) !== (data & mask))
			board.report_mismatch($sformatf("register %s reads %0h, wrote %0h",
				idx.name(), prdata & mask, data & mask));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic write_config(cfg_t c);
		apb_write(cbct_pkg::REG_HUE_LOW_A, DATAW'(c.hue_low_a));
		apb_write(cbct_pkg::REG_HUE_HIGH_A, DATAW'(c.hue_high_a));
		apb_write(cbct_pkg::REG_HUE_LOW_B, DATAW'(c.hue_low_b));
		apb_write(cbct_pkg::REG_HUE_HIGH_B, DATAW'(c.hue_high_b));
		apb_write(cbct_pkg::REG_SAT_MIN, DATAW'(c.sat_min));
		apb_write(cbct_pkg::REG_VAL_MIN, DATAW'(c.val_min));
		apb_write(cbct_pkg::REG_MIN_AREA, DATAW'(c.min_area));
	endtask

	// gap cycles with valid low, then hold the request until taken
	task automatic send_pixel(pixel_t p, int gap);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		hue <= p.hue;
		sat <= p.sat;
		val <= p.val;
		end_of_line <= p.eol;
		end_of_frame <= p.eof;
		@(posedge clk);
		while (pix_stall !== 1'b0) @(posedge clk);
		board.take_pixel(p);
		pixels_sent++;
		@(negedge clk);
	endtask

	// sender pause: no new pixel until every frame result is back and the
	// divider has had time to go quiet
	task automatic drain();
		pix_valid <= 1'b0;
		while (board.frames_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int tx_gap();
		return tx_idle ? $urandom_range(0, 19) : 0;
	endfunction

	function automatic pixel_t px(int h, int s, int v, bit eol, bit eof);
		pixel_t p;
		p.hue = HW'(h);
		p.sat = HW'(s);
		p.val = HW'(v);
		p.eol = eol;
		p.eof = eof;
		return p;
	endfunction

	function automatic cfg_t cfg_of(int hla, int hha, int hlb, int hhb, int smin, int vmin,
			int area);
		cfg_t c;
		c.hue_low_a = HW'(hla);
		c.hue_high_a = HW'(hha);
		c.hue_low_b = HW'(hlb);
		c.hue_high_b = HW'(hhb);
		c.sat_min = HW'(smin);
		c.val_min = HW'(vmin);
		c.min_area = CNTW'(area);
		return c;
	endfunction

	function automatic cfg_t random_config();
		int lo[2];
		int hi[2];
		int t;
		int smin;
		int vmin;
		int area;
		for (int k = 0; k < 2; k++) begin
			lo[k] = $urandom_range(0, 255);
			hi[k] = $urandom_range(lo[k], 255);
			// now and then an inverted, empty window
			if ($urandom_range(0, 5) == 0) begin
				t = lo[k];
				lo[k] = hi[k];
				hi[k] = t;
			end
		end
		smin = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 200);
		vmin = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 200);
		case ($urandom_range(0, 9))
			0: area = AREA_TOP;
			1: area = $urandom_range(0, AREA_TOP);
			default: area = $urandom_range(0, 8);
		endcase
		return cfg_of(lo[0], hi[0], lo[1], hi[1], smin, vmin, area);
	endfunction

	// biased toward the live windows so small frames still find blobs
	function automatic pixel_t random_pixel(bit eol, bit eof);
		pixel_t p;
		int pick;
		pick = $urandom_range(0, 2);
		if (pick < 2)
			p.hue = HW'($urandom_range(board.hue_lo[pick], board.hue_hi[pick]));
		else
			p.hue = HW'($urandom_range(0, 255));
		p.sat = ($urandom_range(0, 3) == 0) ? HW'($urandom_range(0, 255)) :
			HW'($urandom_range(board.sat_floor, 255));
		p.val = ($urandom_range(0, 3) == 0) ? HW'($urandom_range(0, 255)) :
			HW'($urandom_range(board.val_floor, 255));
		p.eol = eol;
		p.eof = eof;
		return p;
	endfunction

	task automatic random_frame();
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
		for (int i = 0; i < len; i++) begin
			send_pixel(random_pixel($urandom_range(0, 5) == 0, i == len - 1), tx_gap());
			random_pixels++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main
		int first_random_frame;
		board = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_valid = 1'b0;
		hue = '0;
		sat = '0;
		val = '0;
		end_of_line = 1'b0;
		end_of_frame = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		pixels_sent = 0;
		random_pixels = 0;
		reg_writes = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset thresholds: inclusive hue edges of both classes, one below and
		// one above each edge, sat and val exactly at and just under the floor.
		// Counts stay under the default area, so centroids stay at zero.
		send_pixel(px(75, 160, 60, 0, 0), tx_gap());
		send_pixel(px(130, 255, 255, 0, 0), tx_gap());
		send_pixel(px(74, 200, 200, 0, 0), tx_gap());
		send_pixel(px(131, 200, 200, 1, 0), tx_gap());
		send_pixel(px(10, 160, 60, 0, 0), tx_gap());
		send_pixel(px(22, 255, 255, 0, 0), tx_gap());
		send_pixel(px(9, 255, 255, 0, 0), tx_gap());
		send_pixel(px(23, 255, 255, 0, 0), tx_gap());
		send_pixel(px(100, 159, 255, 0, 0), tx_gap());
		send_pixel(px(100, 255, 59, 1, 0), tx_gap());
		send_pixel(px(0, 0, 0, 0, 0), tx_gap());
		send_pixel(px(255, 255, 255, 0, 1), tx_gap());
		drain();

		// class a takes everything, class b window inverted (empty), zero
		// floors and zero area; last pixel carries both line and frame marks
		write_config(cfg_of(0, 255, 200, 100, 0, 0, 0));
		send_pixel(px(0, 0, 0, 0, 0), tx_gap());
		send_pixel(px(255, 255, 255, 0, 0), tx_gap());
		send_pixel(px(100, 1, 1, 0, 0), tx_gap());
		send_pixel(px(200, 9, 7, 1, 0), tx_gap());
		send_pixel(px(150, 128, 64, 1, 1), tx_gap());
		drain();

		// single-hue windows at the ends of the range, floors at maximum:
		// first frame misses class a so its last centroid is repeated
		write_config(cfg_of(255, 255, 0, 0, 255, 255, 0));
		send_pixel(px(0, 255, 255, 0, 0), tx_gap());
		send_pixel(px(0, 254, 255, 0, 0), tx_gap());
		send_pixel(px(0, 255, 255, 0, 0), tx_gap());
		send_pixel(px(255, 255, 254, 0, 1), tx_gap());
		// one-pixel frame
		send_pixel(px(255, 255, 255, 1, 1), tx_gap());
		drain();

		// Random phases: fresh thresholds, random gap/stall mix, a few frames,
		// sometimes a full pause between frames.
		first_random_frame = board.frames_checked;
		while (random_pixels < RANDOM_PIXELS ||
				board.frames_checked - first_random_frame < RANDOM_FRAMES) begin
			write_config(random_config());
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(2, 8)) begin
				random_frame();
				if ($urandom_range(0, 4) == 0)
					drain();
			end
			drain();
		end

		$display("covered %0d pixel requests, %0d frame results, %0d register writes",
			pixels_sent, board.frames_checked, reg_writes);
		$display("window-edge and inverted-window frames plus %0d random pixels under gaps",
			random_pixels);
		if (board.mismatches == 0)
			$display("color_blob_centroid_tracker verification clean");
		else
			$display("color_blob_centroid_tracker verification failed");
		$finish;
	end

endmodule
